FILE: design/jes_pkg.sv
package jes_pkg;

  localparam int IMAGE_SIZE_DEF      = 1024;
  localparam int EXP_TABLE_DEPTH_DEF = 1024;

  localparam int Q_W    = 48;   // signed Q4.44
  localparam int FRAC_W = 44;
  localparam int ITER_W = 12;
  localparam int SUM_W  = 29;
  localparam int ROM_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int HALF_W = 24;   // partial product operand width

  localparam logic signed [63:0] QMAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] QMIN   = -64'sh0000_8000_0000_0000;
  localparam logic [51:0]        SQ_MAX = 52'h0_FFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_RE       = 3'd0,
    REG_C_IM       = 3'd1,
    REG_CENTER_RE  = 3'd2,
    REG_CENTER_IM  = 3'd3,
    REG_STEP       = 3'd4,
    REG_ITER_LIMIT = 3'd5,
    REG_BOUND_SQ   = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_RE_W,
    S_MAP_IM,
    S_MAP_IM_W,
    S_SQ_RE,
    S_SQ_IM,
    S_MAG,
    S_LOOK,
    S_ADD,
    S_CROSS,
    S_UPDATE,
    S_DONE
  } state_t;

  localparam logic [47:0] C_RE_RST       = 48'd5205813776343;
  localparam logic [47:0] C_IM_RST       = 48'hF848_1D62_E756; // -8486362355882
  localparam logic [46:0] STEP_RST       = 47'd70368744;
  localparam logic [11:0] ITER_LIMIT_RST = 12'd1000;
  localparam logic [46:0] BOUND_SQ_RST   = 47'd70368744177664;

  function automatic logic [47:0] sat_q(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > QMAX) r = QMAX[47:0];
    else if (v < QMIN) r = QMIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  // restoring division, only used while the table is built
  function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // e^-f in Q30, f in [0,1] Q30, series through the f^16 term
  function automatic longint unsigned exp_neg_q30(input longint unsigned f);
    longint sum;
    longint unsigned term;
    sum  = 64'sd1 << 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      if (i[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r, b, x;
    r = 0;
    x = v;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one table entry from the scaled argument m32 = 16k/depth in Q32
  function automatic logic [ROM_W-1:0] exp_entry(input longint unsigned m32);
    longint unsigned s30, n, v, e1;
    e1  = exp_neg_q30(64'd1 << 30);
    s30 = isqrt64(m32) << 14;
    n   = s30 >> 30;
    v   = exp_neg_q30(s30 & ((64'd1 << 30) - 1));
    for (int i = 0; i < 8; i++) begin
      if (longint'(i) < longint'(n)) v = (v * e1) >> 30;
    end
    v = (v + 64'd8192) >> 14;
    return (v > 64'd65535) ? 16'hFFFF : v[ROM_W-1:0];
  endfunction

endpackage

FILE: design/julia_escape_smooth.sv
// Julia escape-time evaluator with exponential smoothing, one pixel at a time.
// One shared 24x24 multiplier does four partial products per Q4.44 product,
// three products per iteration; iterations are at most the iteration limit.
// Input not ready while busy, including while a result waits for m_tready.
// Reset (rst, synchronous): configuration registers return to defaults, block goes idle.
module julia_escape_smooth import jes_pkg::*; #(
  parameter int IMAGE_SIZE      = IMAGE_SIZE_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // pixel_x[9:0], pixel_y[19:10]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // smooth_value[28:0], iteration_count[40:29]
  output logic                 m_tuser,   // inside_set
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  localparam int HALF  = IMAGE_SIZE / 2;
  localparam int D_W   = $clog2(HALF + 1024) + 1;
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

  // configuration
  logic [47:0]       c_re, c_im, center_re, center_im;
  logic [46:0]       pixel_step, bound_sq;
  logic [ITER_W-1:0] iter_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_re      <= C_RE_RST;
      c_im      <= C_IM_RST;
      center_re <= C_RE_RST;
      center_im <= C_IM_RST;
      pixel_step <= STEP_RST;
      iter_limit <= ITER_LIMIT_RST;
      bound_sq  <= BOUND_SQ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_C_RE:       c_re      <= cfg_data;
        REG_C_IM:       c_im      <= cfg_data;
        REG_CENTER_RE:  center_re <= cfg_data;
        REG_CENTER_IM:  center_im <= cfg_data;
        REG_STEP:       pixel_step <= cfg_data[46:0];
        REG_ITER_LIMIT: iter_limit <= cfg_data[ITER_W-1:0];
        REG_BOUND_SQ:   bound_sq  <= cfg_data[46:0];
        default: ;
      endcase
    end
  end

  // exponential table, constant content
  logic [ROM_W-1:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned M32 = (64'(k) << 36) / EXP_TABLE_DEPTH;
    localparam logic [ROM_W-1:0] ENTRY = exp_entry(M32);
    assign exp_rom[k] = ENTRY;
  end

  state_t state, state_next;

  logic [2:0]        cnt;
  logic              mul_st;
  logic signed [D_W-1:0] dx, dy;
  logic [47:0]       zr, zi;
  logic [51:0]       sq_re, sq_im;
  logic [47:0]       m;
  logic              cont;
  logic [ROM_W-1:0]  rom_q;
  logic [SUM_W-1:0]  sum;
  logic [ITER_W-1:0] n;
  logic [47:0]       prod;
  logic [5:0]        sh_prev;
  logic [95:0]       acc;

  logic [47:0] op_a, op_b, mag_zr, mag_zi;
  logic [D_W-1:0] mag_dx, mag_dy;
  logic [HALF_W-1:0] pa, pb;
  logic [5:0] sh;

  assign mag_zr = zr[47] ? 48'(-zr) : zr;
  assign mag_zi = zi[47] ? 48'(-zi) : zi;
  assign mag_dx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign mag_dy = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);

  assign mul_st = (state == S_MAP_RE) || (state == S_MAP_IM) || (state == S_SQ_RE) ||
                  (state == S_SQ_IM) || (state == S_CROSS);

  always_comb begin
    case (state)
      S_MAP_RE: begin op_a = {1'b0, pixel_step}; op_b = 48'(mag_dx); end
      S_MAP_IM: begin op_a = {1'b0, pixel_step}; op_b = 48'(mag_dy); end
      S_SQ_RE:  begin op_a = mag_zr; op_b = mag_zr; end
      S_SQ_IM:  begin op_a = mag_zi; op_b = mag_zi; end
      S_CROSS:  begin op_a = mag_zr; op_b = mag_zi; end
      default:  begin op_a = '0; op_b = '0; end
    endcase
    pa = cnt[0] ? op_a[47:24] : op_a[23:0];
    pb = cnt[1] ? op_b[47:24] : op_b[23:0];
    sh = 6'(cnt[0] ? 24 : 0) + 6'(cnt[1] ? 24 : 0);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (s_tvalid) state_next = S_MAP_RE;
      S_MAP_RE:   if (cnt == 3'd4) state_next = S_MAP_RE_W;
      S_MAP_RE_W: state_next = S_MAP_IM;
      S_MAP_IM:   if (cnt == 3'd4) state_next = S_MAP_IM_W;
      S_MAP_IM_W: state_next = S_SQ_RE;
      S_SQ_RE:    if (cnt == 3'd4) state_next = S_SQ_IM;
      S_SQ_IM:    if (cnt == 3'd4) state_next = S_MAG;
      S_MAG:      state_next = S_LOOK;
      S_LOOK:     state_next = S_ADD;
      S_ADD:      state_next = cont ? S_CROSS : S_DONE;
      S_CROSS:    if (cnt == 3'd4) state_next = S_UPDATE;
      S_UPDATE:   state_next = S_SQ_RE;
      S_DONE:     if (m_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);
  assign m_tuser  = (n == iter_limit);
  assign m_tdata  = {7'd0, n,
                     (n == iter_limit) ? SUM_W'({iter_limit, 16'd0}) : sum};

  // datapath
  logic signed [63:0] map_prod, map_val;
  logic signed [63:0] a_s, b_s, p_s, x_s, nr, ni;
  logic [47:0]        m_sum_sat;
  logic [48:0]        m_add;
  logic [63:0]        idx_full;
  logic [51:0]        p;

  always_comb begin
    map_prod = 64'(acc[60:0]);
    if (state == S_MAP_RE_W)
      map_val = {{16{center_re[47]}}, center_re} + (dx[D_W-1] ? -map_prod : map_prod);
    else
      map_val = {{16{center_im[47]}}, center_im} + (dy[D_W-1] ? -map_prod : map_prod);

    m_add = 49'(sq_re > SQ_MAX ? SQ_MAX : sq_re) +
            49'(acc[95:44] > SQ_MAX ? SQ_MAX : acc[95:44]);
    m_sum_sat = m_add[48] ? SQ_MAX[47:0] : m_add[47:0];
    idx_full = (64'(m) * 64'(EXP_TABLE_DEPTH)) >> 48;

    a_s = (64'(sq_re) > QMAX) ? QMAX : 64'(sq_re);
    b_s = (64'(sq_im) > QMAX) ? QMAX : 64'(sq_im);
    p   = acc[95:44];
    if (zr[47] != zi[47])
      p_s = (p > 52'h8000_0000_0000) ? QMIN : -64'(p);
    else
      p_s = (64'(p) > QMAX) ? QMAX : 64'(p);
    nr = a_s - b_s + {{16{c_re[47]}}, c_re};
    x_s = p_s <<< 1;
    ni = x_s + {{16{c_im[47]}}, c_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= (mul_st && cnt != 3'd4) ? cnt + 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    // shared multiplier: issue at cnt 0..3, accumulate in the following cycle
    if (mul_st) begin
      prod    <= pa * pb;
      sh_prev <= sh;
      if (cnt == 3'd0) acc <= '0;
      else acc <= acc + (96'(prod) << sh_prev);
    end
    case (state)
      S_IDLE: begin
        dx  <= D_W'(s_tdata[9:0]) - D_W'(HALF);
        dy  <= D_W'(HALF) - D_W'(s_tdata[19:10]);
        n   <= '0;
        sum <= '0;
      end
      S_MAP_RE_W: zr <= sat_q(map_val);
      S_MAP_IM_W: zi <= sat_q(map_val);
      S_SQ_IM:    if (cnt == 3'd0) sq_re <= acc[95:44];
      S_MAG: begin
        sq_im <= acc[95:44];
        m     <= m_sum_sat;
      end
      S_LOOK: begin
        rom_q <= exp_rom[idx_full[IDX_W-1:0]];
        cont  <= ({1'b0, bound_sq} >= m) && (n < iter_limit);
      end
      S_ADD: sum <= sum + SUM_W'(rom_q);
      S_UPDATE: begin
        zr <= sat_q(nr);
        zi <= sat_q(ni);
        n  <= n + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  import jes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HALF_SIZE    = 512;
  localparam int ROM_DEPTH    = 1024;

  typedef struct packed {
    logic [28:0] smooth;
    logic        in_set;
    logic [11:0] count;
  } pixel_result_t;

  class pixel_scoreboard;
    localparam longint QHI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QLO = -64'sh0000_8000_0000_0000;
    localparam longint unsigned SQ_TOP = 64'h0000_FFFF_FFFF_FFFF;

    logic signed [47:0] c_re, c_im, ctr_re, ctr_im;
    logic [46:0]        step;
    logic [11:0]        iter_limit;
    logic [46:0]        bound;
    logic [15:0]        exp_rom [ROM_DEPTH];
    pixel_result_t      pending [$];
    int                 errors;
    int                 checked;
    int                 inside_seen;

    function new();
      longint unsigned e1, s30, n, v;
      c_re     = 48'd5205813776343;
      c_im     = -48'sd8486362355882;
      ctr_re   = 48'd5205813776343;
      ctr_im   = -48'sd8486362355882;
      step     = 47'd70368744;
      iter_limit = 12'd1000;
      bound    = 47'd70368744177664;
      e1 = exp_series(64'd1 << 30);
      for (int k = 0; k < ROM_DEPTH; k++) begin
        s30 = int_sqrt((longint'(k) << 36) / ROM_DEPTH) << 14;
        n   = s30 >> 30;
        v   = exp_series(s30 & ((64'd1 << 30) - 1));
        for (longint unsigned i = 0; i < n; i++) v = (v * e1) >> 30;
        v = (v + 64'd8192) >> 14;
        exp_rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
    endfunction

    // e^-f, Q30 in and out, truncated Taylor series
    function longint unsigned exp_series(longint unsigned f);
      longint          acc;
      longint unsigned term;
      acc  = 64'sd1 << 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
        term = ((term * f) >> 30) / i;
        if (i % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      return (acc < 0) ? 0 : acc;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // exact product of two magnitudes, truncated by 44 bits
    function longint unsigned prod44(longint unsigned a, longint unsigned b);
      logic [95:0] p;
      p = {48'd0, a[47:0]} * {48'd0, b[47:0]};
      return p[95:44];
    endfunction

    function longint clampq(longint v);
      if (v > QHI) return QHI;
      if (v < QLO) return QLO;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint unsigned p;
      p = prod44(magn(a), magn(b));
      if ((a < 0) != (b < 0)) return (p > 64'h8000_0000_0000) ? QLO : -longint'(p);
      return (p > QHI) ? QHI : longint'(p);
    endfunction

    function longint unsigned abs_sq(longint re, longint im);
      longint unsigned a, b;
      a = prod44(magn(re), magn(re));
      b = prod44(magn(im), magn(im));
      if (a > SQ_TOP) a = SQ_TOP;
      if (b > SQ_TOP) b = SQ_TOP;
      a += b;
      return (a > SQ_TOP) ? SQ_TOP : a;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [47:0] val);
      case (idx)
        REG_C_RE:       c_re = val;
        REG_C_IM:       c_im = val;
        REG_CENTER_RE:  ctr_re = val;
        REG_CENTER_IM:  ctr_im = val;
        REG_STEP:       step = val[46:0];
        REG_ITER_LIMIT: iter_limit = val[11:0];
        REG_BOUND_SQ:   bound = val[46:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
      longint          zr, zi, nr, ni;
      longint unsigned m, total, n;
      pixel_result_t   r;
      zr = clampq(longint'(ctr_re) + longint'(step) * (longint'(px) - HALF_SIZE));
      zi = clampq(longint'(ctr_im) + longint'(step) * (HALF_SIZE - longint'(py)));
      m = abs_sq(zr, zi);
      total = exp_rom[m >> 38];
      n = 0;
      while (m <= bound && n < iter_limit) begin
        nr = clampq(qmul(zr, zr) - qmul(zi, zi) + longint'(c_re));
        ni = clampq(2 * qmul(zr, zi) + longint'(c_im));
        zr = nr;
        zi = ni;
        m = abs_sq(zr, zi);
        total += exp_rom[m >> 38];
        n++;
      end
      if (n == iter_limit) begin
        r.smooth = {iter_limit, 16'd0};
        r.in_set = 1'b1;
      end else begin
        r.smooth = total[28:0];
        r.in_set = 1'b0;
      end
      r.count = n[11:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [28:0] sm, logic ins, logic [11:0] cnt);
      pixel_result_t e;
      checked++;
      if (ins) inside_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: smooth=%0d inside=%0d count=%0d",
                         sm, ins, cnt));
      end else begin
        e = pending.pop_front();
        if (sm !== e.smooth)
          report($sformatf("smooth_value %0d, expected %0d", sm, e.smooth));
        if (ins !== e.in_set)
          report($sformatf("inside_set %0b, expected %0b", ins, e.in_set));
        if (cnt !== e.count)
          report($sformatf("iteration_count %0d, expected %0d", cnt, e.count));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;   // pixel_x[9:0], pixel_y[19:10]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;        // smooth_value[28:0], iteration_count[40:29]
  logic                 m_tuser;        // inside_set
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [47:0]          cfg_data = '0;

  pixel_scoreboard sb = new();
  int  cycles;
  int  burst_left;
  int  stall_left;
  int  pixels_sent;
  int  settings_used;
  bit  hold_off;
  bit  calm;

  julia_escape_smooth u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_pixel(s_tdata[9:0], s_tdata[19:10]);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[28:0], m_tuser, m_tdata[40:29]);
  end

  // receiver back-pressure: short random stalls, calm stretches, optional long hold
  always @(negedge clk) begin
    if (($urandom % 200) == 0) calm = !calm;
    if (hold_off) begin
      m_tready = 1'b0;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!calm && ($urandom % 4) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  task write_reg(cfg_reg_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task program_all(logic [47:0] cre, logic [47:0] cim, logic [47:0] xre, logic [47:0] xim,
                   logic [47:0] stp, logic [47:0] mit, logic [47:0] bnd);
    write_reg(REG_C_RE, cre);
    write_reg(REG_C_IM, cim);
    write_reg(REG_CENTER_RE, xre);
    write_reg(REG_CENTER_IM, xim);
    write_reg(REG_STEP, stp);
    write_reg(REG_ITER_LIMIT, mit);
    write_reg(REG_BOUND_SQ, bnd);
    settings_used++;
  endtask

  task send_pixel(logic [9:0] px, logic [9:0] py);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {4'd0, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
    if (burst_left == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // all results back, then a short pause before touching the registers
  task drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function logic [47:0] rand_signed(int shift);
    longint v;
    v = {$urandom, $urandom};
    v = v >>> shift;
    return v[47:0];
  endfunction

  function logic [9:0] rand_coord();
    case ($urandom % 8)
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task random_phase(int items, int iter_cap, bit wild);
    logic [63:0] stp;
    logic [47:0] bnd;
    stp = {$urandom, $urandom};
    stp = stp >> (wild ? $urandom_range(17, 20) : $urandom_range(30, 50));
    bnd = (($urandom % 4) == 0) ? 48'({$urandom, $urandom} >> 17) : 48'd1 << 46;
    program_all(rand_signed(wild ? 16 : $urandom_range(18, 20)),
                rand_signed(wild ? 16 : $urandom_range(18, 20)),
                rand_signed(wild ? 16 : $urandom_range(18, 21)),
                rand_signed(wild ? 16 : $urandom_range(18, 21)),
                stp[47:0], 48'($urandom_range(1, iter_cap)), bnd);
    repeat (items) send_pixel(rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    burst_left = 3;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default registers straight out of reset
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain();

    // zero iteration limit: no iteration, inside with zero sum
    program_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    drain();

    // saturated mapping and constants: huge orbit escapes at once
    program_all(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
                48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'd4095, 48'h7FFF_FFFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    drain();

    // origin orbit with zero bound: ROM entry 0 each step, full-length inside run
    program_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd4095, 48'd0);
    send_pixel(10'd512, 10'd512);
    drain();
    program_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd1 << 30, 48'd17, 48'd1 << 46);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd511, 10'd513);
    send_pixel(10'd0, 10'd0);
    drain();

    for (int p = 0; p < 7; p++) random_phase(45, 40, 1'b0);
    random_phase(20, 12, 1'b1);

    // long receiver hold while pixels keep coming
    program_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd1 << 36, 48'd8, 48'd1 << 46);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    repeat (20) send_pixel(rand_coord(), rand_coord());
    drain();
    random_phase(25, 40, 1'b0);

    $display("%0d pixels over %0d register settings; %0d results checked, %0d inside",
             pixels_sent, settings_used, sb.checked, sb.inside_seen);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
